>>> src/tflc_pkg.sv
// Shared types, constants and level tables for the thermal fan level controller.
package tflc_pkg;

  localparam int TEMP_W     = 8;
  localparam int RPM_W      = 15;
  localparam int ROW_RPM_W  = 12;
  localparam int NUM_LEVELS = 6;
  localparam int LVL_W      = $clog2(NUM_LEVELS) > 0 ? $clog2(NUM_LEVELS) : 1;
  localparam int ROWS       = 6;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int NUM_SLOTS  = 6;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int NUM_PROT   = 6;
  localparam int TRIP_COUNT = 5;
  localparam int CNT_W      = 3;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [RPM_W-1:0] RPM_PER_DEGREE = RPM_W'(100);

  // Level slots: CPU DTS, CPU NTC, SSD1, SSD2, memory, PCIe.
  localparam logic [SLOT_W-1:0] SLOT_CPU_DTS = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_CPU_NTC = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_SSD1    = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_SSD2    = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_MEMORY  = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_PCIE    = SLOT_W'(5);

  // Slots that feed the system fan in each mode.
  localparam logic [NUM_SLOTS-1:0] SYS_USED [2] = '{6'h1C, 6'h34};
  localparam logic [TEMP_W-1:0] CPU_START [2] = '{8'd39, 8'd40};
  localparam logic [TEMP_W-1:0] SYS_START [2] = '{8'd36, 8'd39};

  // Over-temperature limits in shutdown mask bit order:
  // CPU DTS, CPU NTC, SSD1, memory, ambient, SSD2.
  localparam logic [TEMP_W-1:0] PROT_LIMIT [NUM_PROT] =
    '{8'd105, 8'd105, 8'd90, 8'd90, 8'd70, 8'd90};

  localparam logic [ROW_RPM_W-1:0] RPM_TBL [2][NUM_SLOTS][ROWS] = '{
    '{
      '{12'd700, 12'd900, 12'd1100, 12'd1300, 12'd1700, 12'd2800},
      '{12'd700, 12'd900, 12'd1100, 12'd1300, 12'd1700, 12'd2800},
      '{12'd600, 12'd800, 12'd1000, 12'd1300, 12'd1700, 12'd2800},
      '{12'd600, 12'd800, 12'd1000, 12'd1300, 12'd1700, 12'd2800},
      '{12'd600, 12'd800, 12'd1000, 12'd1300, 12'd1700, 12'd2800},
      '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}
    },
    '{
      '{12'd800, 12'd900, 12'd1100, 12'd1300, 12'd1600, 12'd2800},
      '{12'd800, 12'd900, 12'd1100, 12'd1300, 12'd1600, 12'd2800},
      '{12'd500, 12'd600, 12'd900, 12'd1300, 12'd1600, 12'd2800},
      '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
      '{12'd500, 12'd600, 12'd900, 12'd1300, 12'd1500, 12'd2800},
      '{12'd500, 12'd600, 12'd900, 12'd1300, 12'd1500, 12'd2800}
    }
  };

  localparam logic [TEMP_W-1:0] UP_TBL [2][NUM_SLOTS][ROWS] = '{
    '{
      '{8'd60, 8'd70, 8'd78, 8'd89, 8'd96, 8'd96},
      '{8'd60, 8'd68, 8'd75, 8'd82, 8'd88, 8'd88},
      '{8'd53, 8'd54, 8'd55, 8'd58, 8'd62, 8'd62},
      '{8'd64, 8'd65, 8'd66, 8'd72, 8'd78, 8'd78},
      '{8'd55, 8'd60, 8'd65, 8'd69, 8'd72, 8'd72},
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
    },
    '{
      '{8'd60, 8'd70, 8'd78, 8'd89, 8'd96, 8'd96},
      '{8'd60, 8'd68, 8'd75, 8'd82, 8'd88, 8'd87},
      '{8'd60, 8'd62, 8'd65, 8'd67, 8'd71, 8'd66},
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd55, 8'd60, 8'd65, 8'd69, 8'd72, 8'd72},
      '{8'd54, 8'd57, 8'd60, 8'd64, 8'd71, 8'd71}
    }
  };

  localparam logic [TEMP_W-1:0] DN_TBL [2][NUM_SLOTS][ROWS] = '{
    '{
      '{8'd39, 8'd57, 8'd67, 8'd75, 8'd85, 8'd95},
      '{8'd39, 8'd57, 8'd65, 8'd72, 8'd79, 8'd86},
      '{8'd36, 8'd51, 8'd52, 8'd53, 8'd56, 8'd60},
      '{8'd36, 8'd62, 8'd63, 8'd64, 8'd69, 8'd76},
      '{8'd36, 8'd53, 8'd58, 8'd63, 8'd67, 8'd70},
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
    },
    '{
      '{8'd40, 8'd57, 8'd67, 8'd75, 8'd87, 8'd95},
      '{8'd40, 8'd57, 8'd65, 8'd72, 8'd79, 8'd86},
      '{8'd39, 8'd52, 8'd56, 8'd59, 8'd61, 8'd64},
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd39, 8'd53, 8'd58, 8'd63, 8'd67, 8'd70},
      '{8'd39, 8'd50, 8'd54, 8'd58, 8'd62, 8'd69}
    }
  };

  typedef struct packed {
    logic [TEMP_W-1:0] cpu_dts_temp;
    logic [TEMP_W-1:0] ambient_temp;
    logic [TEMP_W-1:0] ssd1_temp;
    logic [TEMP_W-1:0] pcie_temp;
    logic [TEMP_W-1:0] cpu_ntc_temp;
    logic [TEMP_W-1:0] memory_temp;
    logic [TEMP_W-1:0] ssd2_temp;
    logic              acpi_mode;
    logic              cpu_fan_enable;
    logic              sys_fan_enable;
  } in_t;

  typedef struct packed {
    logic [RPM_W-1:0]    cpu_fan_rpm;
    logic                cpu_fan_update;
    logic [RPM_W-1:0]    sys_fan_rpm;
    logic                sys_fan_update;
    logic [NUM_PROT-1:0] shutdown_mask;
  } out_t;

  // Levels beyond the table use its last row.
  function automatic logic [ROW_W-1:0] row_of(input logic [LVL_W-1:0] lvl);
    logic [ROW_W-1:0] r;
    if (32'(lvl) >= ROWS) begin
      r = ROW_W'(ROWS - 1);
    end else begin
      r = ROW_W'(lvl);
    end
    return r;
  endfunction

endpackage

>>> src/thermal_fan_level_controller_unit.sv
// Top level of the thermal fan level controller: handshakes, state and fan targets.
module thermal_fan_level_controller_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tflc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tflc_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);
  // Each input transaction is one thermal tick. It is captured in an input
  // register, worked through the level steps, over-temperature counters and
  // fan target arithmetic in a single combinational pass, and lands in the
  // result register. A new tick can be accepted on every cycle while the
  // output side does not stall. The rate of one transaction per cycle is
  // set by the single compute stage: the sensor levels and counters are
  // updated at the same edge that loads the result, so the next tick already
  // sees them. Stall from the output side reaches the input side only when
  // both registers are full. The table-select register (cfg_data) is always
  // ready and must only be written while no tick is in flight; it selects the
  // integrated or discrete graphics tables.
  import tflc_pkg::*;

  logic                 mode;
  logic                 s1_valid;
  in_t                  s1_data;
  logic                 adv;
  logic [LVL_W-1:0]     levels [NUM_SLOTS];
  logic [LVL_W-1:0]     levels_next [NUM_SLOTS];
  logic [CNT_W-1:0]     counts [NUM_PROT];
  logic [CNT_W-1:0]     counts_next [NUM_PROT];
  logic [TEMP_W-1:0]    slot_temp [NUM_SLOTS];
  logic                 slot_en [NUM_SLOTS];
  logic [ROW_RPM_W-1:0] slot_rpm [NUM_SLOTS];
  logic [TEMP_W-1:0]    prot_temp [NUM_PROT];
  logic [NUM_PROT-1:0]  trips;
  logic [ROW_RPM_W-1:0] cpu_best;
  logic [ROW_RPM_W-1:0] sys_best;
  logic [RPM_W-1:0]     cpu_amb_add;
  logic [RPM_W-1:0]     sys_amb_add;
  out_t                 result;
  logic                 levels_ok;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  // Route the temperatures to the level slots and decide which slots move
  // this tick. A slot that its fan does not use in this mode holds its level.
  always_comb begin
    slot_temp[SLOT_CPU_DTS] = s1_data.cpu_dts_temp;
    slot_temp[SLOT_CPU_NTC] = s1_data.cpu_ntc_temp;
    slot_temp[SLOT_SSD1]    = s1_data.ssd1_temp;
    slot_temp[SLOT_SSD2]    = s1_data.ssd2_temp;
    slot_temp[SLOT_MEMORY]  = s1_data.memory_temp;
    slot_temp[SLOT_PCIE]    = s1_data.pcie_temp;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (i < 2) begin
        slot_en[i] = s1_data.cpu_fan_enable;
      end else begin
        slot_en[i] = s1_data.sys_fan_enable && SYS_USED[mode][i];
      end
    end
    prot_temp[0] = s1_data.cpu_dts_temp;
    prot_temp[1] = s1_data.cpu_ntc_temp;
    prot_temp[2] = s1_data.ssd1_temp;
    prot_temp[3] = s1_data.memory_temp;
    prot_temp[4] = s1_data.ambient_temp;
    prot_temp[5] = s1_data.ssd2_temp;
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_level
    tflc_level_step u_step (
      .temp       (slot_temp[g]),
      .level      (levels[g]),
      .mode       (mode),
      .slot       (SLOT_W'(g)),
      .enable     (slot_en[g]),
      .level_next (levels_next[g]),
      .rpm        (slot_rpm[g])
    );
  end

  for (genvar g = 0; g < NUM_PROT; g++) begin : g_prot
    tflc_overtemp u_ot (
      .temp       (prot_temp[g]),
      .limit      (PROT_LIMIT[g]),
      .count      (counts[g]),
      .enable     (s1_data.acpi_mode),
      .count_next (counts_next[g]),
      .trip       (trips[g])
    );
  end

  // Fan targets: the largest table RPM among the fan's slots (unused slots
  // read as zero) plus 100 RPM per degree of ambient above the start point.
  always_comb begin
    cpu_best = (slot_rpm[SLOT_CPU_DTS] > slot_rpm[SLOT_CPU_NTC]) ?
               slot_rpm[SLOT_CPU_DTS] : slot_rpm[SLOT_CPU_NTC];
    sys_best = '0;
    for (int i = 2; i < NUM_SLOTS; i++) begin
      if (slot_rpm[i] > sys_best) begin
        sys_best = slot_rpm[i];
      end
    end
    if (s1_data.ambient_temp >= CPU_START[mode]) begin
      cpu_amb_add = RPM_W'(s1_data.ambient_temp - CPU_START[mode]) * RPM_PER_DEGREE;
    end else begin
      cpu_amb_add = '0;
    end
    if (s1_data.ambient_temp >= SYS_START[mode]) begin
      sys_amb_add = RPM_W'(s1_data.ambient_temp - SYS_START[mode]) * RPM_PER_DEGREE;
    end else begin
      sys_amb_add = '0;
    end
    result.cpu_fan_rpm    = s1_data.cpu_fan_enable ?
                            RPM_W'(cpu_best) + cpu_amb_add : '0;
    result.cpu_fan_update = s1_data.cpu_fan_enable;
    result.sys_fan_rpm    = s1_data.sys_fan_enable ?
                            RPM_W'(sys_best) + sys_amb_add : '0;
    result.sys_fan_update = s1_data.sys_fan_enable;
    result.shutdown_mask  = trips;
  end

  // Sensor state moves only when a tick leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        levels[i] <= '0;
      end
      for (int i = 0; i < NUM_PROT; i++) begin
        counts[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        levels[i] <= levels_next[i];
      end
      for (int i = 0; i < NUM_PROT; i++) begin
        counts[i] <= counts_next[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result;
    end
  end

  always_comb begin
    levels_ok = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (32'(levels[i]) > NUM_LEVELS - 1) begin
        levels_ok = 1'b0;
      end
    end
  end

  a_levels_in_range: assert property (@(posedge clk) disable iff (rst) levels_ok)
    else $error("sensor level beyond the top level");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("input taken while both registers are full");

  a_no_acpi_no_trip: assert property (@(posedge clk) disable iff (rst)
    adv && !s1_data.acpi_mode |=> out_data.shutdown_mask == '0)
    else $error("shutdown raised without ACPI mode");

  a_cpu_off_holds: assert property (@(posedge clk) disable iff (rst)
    adv && !s1_data.cpu_fan_enable |=>
      levels[SLOT_CPU_DTS] == $past(levels[SLOT_CPU_DTS]) &&
      levels[SLOT_CPU_NTC] == $past(levels[SLOT_CPU_NTC]))
    else $error("disabled CPU fan changed its levels");

  a_cpu_off_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.cpu_fan_update |-> out_data.cpu_fan_rpm == '0)
    else $error("disabled CPU fan has a nonzero target");

endmodule

>>> src/tflc_level_step.sv
// One sensor's hysteresis level step and table RPM lookup.
module tflc_level_step (
  input  logic [tflc_pkg::TEMP_W-1:0]    temp,
  input  logic [tflc_pkg::LVL_W-1:0]     level,
  input  logic                           mode,
  input  logic [tflc_pkg::SLOT_W-1:0]    slot,
  input  logic                           enable,
  output logic [tflc_pkg::LVL_W-1:0]     level_next,
  output logic [tflc_pkg::ROW_RPM_W-1:0] rpm
);
  import tflc_pkg::*;

  logic [ROW_W-1:0] cur_row;
  logic             rise;
  logic             fall;
  logic [LVL_W-1:0] stepped;

  // Both tests look at the old level; if both fire the level stays put.
  always_comb begin
    cur_row = row_of(level);
    rise    = (level < LVL_W'(NUM_LEVELS - 1)) && (temp >= UP_TBL[mode][slot][cur_row]);
    fall    = (level != '0) && (temp < DN_TBL[mode][slot][cur_row]);
    stepped = level;
    if (rise && !fall) begin
      stepped = level + LVL_W'(1);
    end else if (fall && !rise) begin
      stepped = level - LVL_W'(1);
    end
    level_next = enable ? stepped : level;
    rpm        = enable ? RPM_TBL[mode][slot][row_of(level_next)] : '0;
  end

endmodule

>>> src/tflc_overtemp.sv
// One over-temperature counter with its shutdown trip.
module tflc_overtemp (
  input  logic [tflc_pkg::TEMP_W-1:0] temp,
  input  logic [tflc_pkg::TEMP_W-1:0] limit,
  input  logic [tflc_pkg::CNT_W-1:0]  count,
  input  logic                        enable,
  output logic [tflc_pkg::CNT_W-1:0]  count_next,
  output logic                        trip
);
  import tflc_pkg::*;

  logic [CNT_W-1:0] stepped;
  logic             over;

  always_comb begin
    if (temp > limit) begin
      stepped = (count == CNT_MAX) ? count : count + CNT_W'(1);
    end else begin
      stepped = (count == '0) ? count : count - CNT_W'(1);
    end
    over       = 32'(stepped) > TRIP_COUNT;
    trip       = enable && over;
    count_next = !enable ? count : (over ? '0 : stepped);
  end

endmodule
